[sv/ajp_pkg.sv]
// Shared types and codes for the affinity job picker.
// No dependencies; imported by the top level and the testbench.
`timescale 1ns / 1ps

package ajp_pkg;

	// Input operation codes
	localparam logic [1:0] OP_REQUEST = 2'd0;
	localparam logic [1:0] OP_SET     = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;

	// Job status codes held in the table
	localparam logic [1:0] JOB_PENDING  = 2'd0;
	localparam logic [1:0] JOB_RUNNING  = 2'd1;
	localparam logic [1:0] JOB_FINISHED = 2'd2;

	// Configuration register indexes
	localparam logic CFG_COUNT_A = 1'b0;
	localparam logic CFG_COUNT_B = 1'b1;

	localparam int CNT_W = 5;

	// Sequencer states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_MARK,
		S_DONE
	} ajp_state_t;

endpackage

[sv/ajp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ajp_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

[sv/affinity_job_picker_top.sv]
// Affinity job picker: job status table with a sequential affinity scan.
// Depends on ajp_pkg and ajp_ram.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | operation .. new_status
//   out     | output    | out_valid / out_stall| granted .. reused
//   cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// A request scans at most njobs entries (njobs = count_a * count_b after
// saturation): the scan reads one table entry a cycle through the RAM read port.
// A set or an unknown operation goes from S_IDLE straight to S_DONE; a clear writes
// all DEPTH entries, DEPTH = MAX_SEG_A * MAX_SEG_B, one entry written per cycle.
// After reset the same clearing pass runs before the first transfer.
// One result register feeds out; a stalled result holds the sequencer in S_DONE.
`timescale 1ns / 1ps

module affinity_job_picker_top #(
	parameter int MAX_SEG_A = 16,
	parameter int MAX_SEG_B = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [ajp_pkg::CNT_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                operation,
	input  logic                      has_previous,
	input  logic [3:0]                prev_a,
	input  logic [3:0]                prev_b,
	input  logic [7:0]                target_job,
	input  logic [1:0]                new_status,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      granted,
	output logic [7:0]                job_id,
	output logic [3:0]                seg_a,
	output logic [3:0]                seg_b,
	output logic                      reused
);

	import ajp_pkg::*;

	localparam int DEPTH = MAX_SEG_A * MAX_SEG_B;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SAW   = (MAX_SEG_A > 1) ? $clog2(MAX_SEG_A) : 1;
	localparam int SBW   = (MAX_SEG_B > 1) ? $clog2(MAX_SEG_B) : 1;
	localparam int CA_W  = $clog2(MAX_SEG_A + 1);
	localparam int CB_W  = $clog2(MAX_SEG_B + 1);
	localparam int EA_W  = (CA_W > CNT_W) ? CA_W : CNT_W;
	localparam int EB_W  = (CB_W > CNT_W) ? CB_W : CNT_W;
	localparam int NJ_W  = CA_W + CB_W;
	localparam int TW    = (NJ_W > 8) ? NJ_W : 8;
	localparam int MA_W  = (SAW > 4) ? SAW : 4;
	localparam int MB_W  = (SBW > 4) ? SBW : 4;
	localparam int IXW   = (AW > 8) ? AW : 8;

	ajp_state_t state_q, state_d;

	logic [CNT_W-1:0] count_a_q, count_b_q;
	logic [CA_W-1:0]  na;
	logic [CB_W-1:0]  nb;
	logic [NJ_W-1:0]  njobs;

	logic [AW-1:0]    clr_q;
	logic             clr_rsp_q;
	logic             hp_q;
	logic [3:0]       pa_q, pb_q;

	// scan address side
	logic [AW-1:0]    idx_q;
	logic [SAW-1:0]   a_q;
	logic [SBW-1:0]   b_q;
	logic             more_q;
	logic             last_issue;

	// scan check side, registered from the address side
	logic             chk_vld_s1;
	logic [AW-1:0]    chk_idx_s1;
	logic [SAW-1:0]   chk_a_s1;
	logic [SBW-1:0]   chk_b_s1;

	// selected job
	logic             found_q, reuse_q;
	logic [AW-1:0]    sel_id_q;
	logic [SAW-1:0]   sel_a_q;
	logic [SBW-1:0]   sel_b_q;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [1:0]       ram_wdata;
	logic [1:0]       ram_rdata;

	logic             accept;
	logic             is_pend, is_match, out_load, set_ok;

	// Saturate counts to the table size and form the batch size
	always_comb begin
		na    = (EA_W'(count_a_q) > EA_W'(MAX_SEG_A)) ? CA_W'(MAX_SEG_A) : CA_W'(count_a_q);
		nb    = (EB_W'(count_b_q) > EB_W'(MAX_SEG_B)) ? CB_W'(MAX_SEG_B) : CB_W'(count_b_q);
		njobs = NJ_W'(na) * NJ_W'(nb);
	end

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign set_ok   = (TW'(target_job) < TW'(njobs)) && (new_status <= JOB_FINISHED);

	assign last_issue = (CA_W'(a_q) == na - CA_W'(1)) && (CB_W'(b_q) == nb - CB_W'(1));

	assign is_pend  = chk_vld_s1 && (ram_rdata == JOB_PENDING);
	assign is_match = hp_q && ((MA_W'(chk_a_s1) == MA_W'(pa_q)) ||
		(MB_W'(chk_b_s1) == MB_W'(pb_q)));

	assign out_load = (state_q == S_DONE) && (!out_valid || !out_stall);

	// Select the table write source
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = JOB_PENDING;
		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_IDLE: begin
				ram_we    = accept && (operation == OP_SET) && set_ok;
				ram_waddr = AW'(IXW'(target_job));
				ram_wdata = new_status;
			end
			S_MARK: begin
				ram_we    = 1'b1;
				ram_waddr = sel_id_q;
				ram_wdata = JOB_RUNNING;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	ajp_ram #(
		.WIDTH (2),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_table (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (idx_q),
		.rd_data (ram_rdata)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = clr_rsp_q ? S_DONE : S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (operation == OP_REQUEST) begin
						state_d = S_SCAN;
					end else if (operation == OP_CLEAR) begin
						state_d = S_CLEAR;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SCAN: begin
				if (is_pend && (!hp_q || is_match)) begin
					state_d = S_MARK;
				end else if (!chk_vld_s1 && !more_q) begin
					state_d = found_q ? S_MARK : S_DONE;
				end
			end
			S_MARK: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q <= CNT_W'(1);
			count_b_q <= CNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COUNT_A: count_a_q <= cfg_data;
				default:     count_b_q <= cfg_data;
			endcase
		end
	end

	// Sequencer control: clearing pass, scan counters, selection flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clr_rsp_q  <= 1'b0;
			more_q     <= 1'b0;
			chk_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
			reuse_q    <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			// advance the clearing pass
			if (state_q == S_CLEAR) begin
				clr_q <= (clr_q == AW'(DEPTH - 1)) ? '0 : clr_q + AW'(1);
			end

			if (accept) begin
				clr_rsp_q  <= (operation == OP_CLEAR);
				more_q     <= (operation == OP_REQUEST) && (njobs != '0);
				chk_vld_s1 <= 1'b0;
				found_q    <= 1'b0;
				reuse_q    <= 1'b0;
			end else if (state_q == S_SCAN) begin
				if (state_d != S_SCAN) begin
					more_q     <= 1'b0;
					chk_vld_s1 <= 1'b0;
				end else begin
					chk_vld_s1 <= more_q;
					if (more_q && last_issue) begin
						more_q <= 1'b0;
					end
				end
				// hold the first pending job, replace it by an affinity match
				if (is_pend && (!found_q || is_match)) begin
					found_q <= 1'b1;
					reuse_q <= is_match;
				end
			end

			// hold the result until its transfer
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Scan datapath: address counters, check stage and selected job
	always_ff @(posedge clk) begin
		if (accept) begin
			hp_q  <= has_previous;
			pa_q  <= prev_a;
			pb_q  <= prev_b;
			idx_q <= '0;
			a_q   <= '0;
			b_q   <= '0;
		end else if (state_q == S_SCAN) begin
			chk_idx_s1 <= idx_q;
			chk_a_s1   <= a_q;
			chk_b_s1   <= b_q;
			if (more_q) begin
				idx_q <= idx_q + AW'(1);
				if (CB_W'(b_q) == nb - CB_W'(1)) begin
					b_q <= '0;
					a_q <= a_q + SAW'(1);
				end else begin
					b_q <= b_q + SBW'(1);
				end
			end
			if (is_pend && (!found_q || is_match)) begin
				sel_id_q <= chk_idx_s1;
				sel_a_q  <= chk_a_s1;
				sel_b_q  <= chk_b_s1;
			end
		end

		// load the result register
		if (out_load) begin
			granted <= found_q;
			job_id  <= found_q ? 8'(sel_id_q) : 8'd0;
			seg_a   <= found_q ? 4'(sel_a_q) : 4'd0;
			seg_b   <= found_q ? 4'(sel_b_q) : 4'd0;
			reused  <= found_q && reuse_q;
		end
	end

endmodule

[dv/tb_affinity_job_picker_top.sv]
// Self-checking testbench for affinity_job_picker_top: job table scans, sets and clears.
// Depends on ajp_pkg and the RTL of affinity_job_picker_top; keeps its own job table model.
`timescale 1ns / 1ps

module tb_affinity_job_picker_top;
	import ajp_pkg::*;

	localparam int SEG_A_MAX = 16;
	localparam int SEG_B_MAX = 16;
	localparam int TABLE_DEPTH = SEG_A_MAX * SEG_B_MAX;
	localparam logic [1:0] OP_UNKNOWN = 2'd3;
	localparam logic [1:0] STATUS_BAD = 2'd3;
	localparam int IDLE_PCT = 31;

	typedef struct packed {
		logic [1:0] operation;
		logic       has_previous;
		logic [3:0] prev_a;
		logic [3:0] prev_b;
		logic [7:0] target_job;
		logic [1:0] new_status;
	} job_cmd_t;

	typedef struct packed {
		logic       granted;
		logic [7:0] job_id;
		logic [3:0] seg_a;
		logic [3:0] seg_b;
		logic       reused;
	} grant_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic             cfg_index = 1'b0;
	logic [CNT_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [1:0]       operation = '0;
	logic             has_previous = 1'b0;
	logic [3:0]       prev_a = '0;
	logic [3:0]       prev_b = '0;
	logic [7:0]       target_job = '0;
	logic [1:0]       new_status = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic             granted;
	logic [7:0]       job_id;
	logic [3:0]       seg_a;
	logic [3:0]       seg_b;
	logic             reused;

	// Model state: job table and count registers
	logic [1:0]       job_tbl [TABLE_DEPTH];
	logic [CNT_W-1:0] cnt_a = 5'd1;
	logic [CNT_W-1:0] cnt_b = 5'd1;

	job_cmd_t cmd_backlog [$];
	grant_t   grants_due [$];

	bit steady = 1'b0;
	int n_errors = 0;
	int n_results = 0;
	int n_grants = 0;
	int n_reused = 0;
	int n_settings = 1;

	affinity_job_picker_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.has_previous (has_previous),
		.prev_a       (prev_a),
		.prev_b       (prev_b),
		.target_job   (target_job),
		.new_status   (new_status),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.granted      (granted),
		.job_id       (job_id),
		.seg_a        (seg_a),
		.seg_b        (seg_b),
		.reused       (reused)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		foreach (job_tbl[i]) job_tbl[i] = JOB_PENDING;
	end

	// Apply one command to the table model and return the grant it yields
	function automatic grant_t pick_job(job_cmd_t c);
		grant_t g;
		int na;
		int nb;
		int idx;
		bit hit;
		bit done;
		g = '0;
		hit = 1'b0;
		done = 1'b0;
		na = (cnt_a > SEG_A_MAX) ? SEG_A_MAX : cnt_a;
		nb = (cnt_b > SEG_B_MAX) ? SEG_B_MAX : cnt_b;
		case (c.operation)
			OP_REQUEST: begin
				for (int a = 0; a < na && !done; a++) begin
					for (int b = 0; b < nb && !done; b++) begin
						idx = a * nb + b;
						if (job_tbl[idx] == JOB_PENDING) begin
							// first pending job is the fallback
							if (!hit) begin
								hit = 1'b1;
								g.job_id = idx[7:0];
								g.seg_a = a[3:0];
								g.seg_b = b[3:0];
								if (!c.has_previous) done = 1'b1;
							end
							// shared segment wins over the fallback
							if (!done && c.has_previous && (a == c.prev_a || b == c.prev_b)) begin
								g.job_id = idx[7:0];
								g.seg_a = a[3:0];
								g.seg_b = b[3:0];
								g.reused = 1'b1;
								done = 1'b1;
							end
						end
					end
				end
				if (hit) begin
					g.granted = 1'b1;
					job_tbl[g.job_id] = JOB_RUNNING;
				end else begin
					g = '0;
				end
			end
			OP_SET: begin
				if (c.target_job < na * nb && c.new_status != STATUS_BAD)
					job_tbl[c.target_job] = c.new_status;
			end
			OP_CLEAR: begin
				foreach (job_tbl[i]) job_tbl[i] = JOB_PENDING;
			end
			default: ;
		endcase
		return g;
	endfunction

	// Drive commands; predict each one at its transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				grants_due.insert(grants_due.size(), pick_job({operation, has_previous,
					prev_a, prev_b, target_job, new_status}));
			if (!in_valid || !in_stall) begin
				if (cmd_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
					{operation, has_previous, prev_a, prev_b, target_job, new_status}
						<= cmd_backlog.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Stall results at random and check each transfer against the oldest grant due
	always @(posedge clk) begin
		grant_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				n_results++;
				if (grants_due.size() == 0) begin
					$error("result with no command outstanding: granted %0d job_id %0d",
						granted, job_id);
					n_errors++;
				end else begin
					want = grants_due.pop_front();
					if (granted !== want.granted) begin
						$error("granted: expected %0d, got %0d", want.granted, granted);
						n_errors++;
					end
					if (job_id !== want.job_id) begin
						$error("job_id: expected %0d, got %0d", want.job_id, job_id);
						n_errors++;
					end
					if (seg_a !== want.seg_a) begin
						$error("seg_a: expected %0d, got %0d", want.seg_a, seg_a);
						n_errors++;
					end
					if (seg_b !== want.seg_b) begin
						$error("seg_b: expected %0d, got %0d", want.seg_b, seg_b);
						n_errors++;
					end
					if (reused !== want.reused) begin
						$error("reused: expected %0d, got %0d", want.reused, reused);
						n_errors++;
					end
					if (want.granted) n_grants++;
					if (want.reused) n_reused++;
				end
			end
			out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
		end
	end

	task automatic push_cmd(input logic [1:0] op, input logic hp, input logic [3:0] pa,
		input logic [3:0] pb, input logic [7:0] tj, input logic [1:0] st);
		cmd_backlog.insert(cmd_backlog.size(), {op, hp, pa, pb, tj, st});
	endtask

	// Hold until every command has transferred and every grant has come back
	task automatic drain();
		while (cmd_backlog.size() != 0 || in_valid || grants_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_count(input logic idx, input logic [CNT_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_COUNT_A) cnt_a = val;
		else cnt_b = val;
	endtask

	task automatic set_batch(input logic [CNT_W-1:0] a_cfg, input logic [CNT_W-1:0] b_cfg);
		drain();
		write_count(CFG_COUNT_A, a_cfg);
		write_count(CFG_COUNT_B, b_cfg);
		n_settings++;
	endtask

	// Random commands, mostly requests and sets aimed inside the batch
	task automatic run_batch(input logic [CNT_W-1:0] a_cfg, input logic [CNT_W-1:0] b_cfg,
		input int n_cmds);
		job_cmd_t c;
		int na;
		int nb;
		int r;
		set_batch(a_cfg, b_cfg);
		na = (cnt_a > SEG_A_MAX) ? SEG_A_MAX : cnt_a;
		nb = (cnt_b > SEG_B_MAX) ? SEG_B_MAX : cnt_b;
		repeat (n_cmds) begin
			r = $urandom_range(99);
			c.operation = (r < 60) ? OP_REQUEST : (r < 88) ? OP_SET :
				(r < 96) ? OP_CLEAR : OP_UNKNOWN;
			c.has_previous = ($urandom_range(99) < 75);
			c.prev_a = (na > 0 && $urandom_range(99) < 85) ? 4'($urandom_range(na - 1))
				: 4'($urandom_range(15));
			c.prev_b = (nb > 0 && $urandom_range(99) < 85) ? 4'($urandom_range(nb - 1))
				: 4'($urandom_range(15));
			c.target_job = (na * nb > 0 && $urandom_range(99) < 80)
				? 8'($urandom_range(na * nb - 1)) : 8'($urandom_range(255));
			c.new_status = ($urandom_range(99) < 90) ? 2'($urandom_range(2)) : STATUS_BAD;
			cmd_backlog.insert(cmd_backlog.size(), c);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Single-job batch: grant, exhaustion, ignored sets and unknown operation
		push_cmd(OP_REQUEST, 1'b0, 4'd0, 4'd0, 8'd0, JOB_PENDING);
		push_cmd(OP_REQUEST, 1'b1, 4'd0, 4'd0, 8'd0, JOB_PENDING);
		push_cmd(OP_UNKNOWN, 1'b1, 4'hf, 4'hf, 8'hff, STATUS_BAD);
		push_cmd(OP_SET, 1'b0, 4'd0, 4'd0, 8'd0, STATUS_BAD);
		push_cmd(OP_SET, 1'b0, 4'd0, 4'd0, 8'd255, JOB_PENDING);
		push_cmd(OP_SET, 1'b0, 4'd0, 4'd0, 8'd0, JOB_PENDING);
		push_cmd(OP_REQUEST, 1'b1, 4'd0, 4'd0, 8'd0, JOB_PENDING);
		push_cmd(OP_CLEAR, 1'b0, 4'd0, 4'd0, 8'd0, JOB_PENDING);

		// 4 x 5 batch: match on A, match on B, fallback, edges of the batch
		set_batch(5'd4, 5'd5);
		push_cmd(OP_REQUEST, 1'b1, 4'd2, 4'd15, 8'd0, JOB_PENDING);
		push_cmd(OP_REQUEST, 1'b1, 4'd15, 4'd3, 8'd0, JOB_PENDING);
		push_cmd(OP_REQUEST, 1'b1, 4'd15, 4'd15, 8'd0, JOB_PENDING);
		push_cmd(OP_SET, 1'b0, 4'd0, 4'd0, 8'd19, JOB_FINISHED);
		push_cmd(OP_SET, 1'b0, 4'd0, 4'd0, 8'd20, JOB_RUNNING);
		push_cmd(OP_REQUEST, 1'b0, 4'd15, 4'd15, 8'd0, JOB_PENDING);
		push_cmd(OP_SET, 1'b1, 4'd0, 4'd0, 8'd1, JOB_PENDING);
		push_cmd(OP_SET, 1'b0, 4'd0, 4'd0, 8'd2, JOB_RUNNING);

		// Full 16 x 16 batch: last segments and last entry
		set_batch(5'd16, 5'd16);
		push_cmd(OP_REQUEST, 1'b1, 4'd15, 4'd15, 8'd0, JOB_PENDING);
		push_cmd(OP_SET, 1'b0, 4'd0, 4'd0, 8'd255, JOB_FINISHED);
		push_cmd(OP_REQUEST, 1'b1, 4'd15, 4'd0, 8'd0, JOB_PENDING);
		push_cmd(OP_SET, 1'b0, 4'd0, 4'd0, 8'd255, STATUS_BAD);
		push_cmd(OP_CLEAR, 1'b1, 4'hf, 4'hf, 8'hff, STATUS_BAD);
		push_cmd(OP_UNKNOWN, 1'b0, 4'd0, 4'd0, 8'd0, JOB_PENDING);

		// Random batches, saturated and empty counts among them
		run_batch(5'd1, 5'd1, 40);
		steady = 1'b1;
		run_batch(5'd16, 5'd16, 120);
		drain();
		steady = 1'b0;
		run_batch(5'd4, 5'd5, 130);
		run_batch(5'd0, 5'd3, 40);
		run_batch(5'd31, 5'd2, 80);
		run_batch(5'd3, 5'd17, 100);
		run_batch(5'd2, 5'd2, 120);
		run_batch(5'd7, 5'd16, 120);
		run_batch(5'd5, 5'd1, 100);

		// Let any stray result show up before the verdict
		drain();
		repeat (300) @(posedge clk);

		$display("Checked %0d results over %0d batch settings: %0d grants, %0d on a shared segment.",
			n_results, n_settings, n_grants, n_reused);
		if (n_errors == 0 && grants_due.size() == 0) begin
			$display("affinity_job_picker_top regression: pass");
		end else begin
			$display("Failures: %0d mismatches, %0d results never seen.", n_errors,
				grants_due.size());
			$display("affinity_job_picker_top regression: fail");
		end
		$finish;
	end

	// Bound the run well past the slowest legal schedule
	initial begin
		#20_000_000;
		$display("Timed out with %0d commands queued, %0d results outstanding.",
			cmd_backlog.size(), grants_due.size());
		$display("affinity_job_picker_top regression: fail");
		$finish;
	end

endmodule

[affinity_job_picker_top.f]
sv/ajp_pkg.sv
sv/ajp_ram.sv
sv/affinity_job_picker_top.sv
dv/tb_affinity_job_picker_top.sv
